// ===== hw/rtl/fpec_pkg.sv =====
// Package with the shared constants, types and codes of the flash program/erase controller.
package fpec_pkg;

  localparam int ARRAY_WORDS     = 1024;
  localparam int PAGE_WORDS      = 32;
  localparam int HALF_PAGE_WORDS = 16;

  localparam int ADDR_W = $clog2(ARRAY_WORDS);
  localparam int PAGE_W = $clog2(PAGE_WORDS);
  localparam int HP_W   = $clog2(HALF_PAGE_WORDS);
  localparam int FILL_W = HP_W + 1;
  localparam int DATA_W = 32;
  localparam int TICK_W = 16;
  localparam int CFG_IDX_W = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DATA_W-1:0] KEY_UNLOCK_A = 32'h89AB_CDEF;
  localparam logic [DATA_W-1:0] KEY_UNLOCK_B = 32'h0203_0405;
  localparam logic [DATA_W-1:0] KEY_PROG_A   = 32'h8C9D_AEBF;
  localparam logic [DATA_W-1:0] KEY_PROG_B   = 32'h1314_1516;

  localparam logic [TICK_W-1:0] ERASE_TICKS_RESET   = 16'd100;
  localparam logic [TICK_W-1:0] PROGRAM_TICKS_RESET = 16'd20;

  // Function codes of the request word.
  localparam logic [2:0] FUNC_REG_READ  = 3'd0;
  localparam logic [2:0] FUNC_REG_WRITE = 3'd1;
  localparam logic [2:0] FUNC_MEM_READ  = 3'd2;
  localparam logic [2:0] FUNC_MEM_WRITE = 3'd3;
  localparam logic [2:0] FUNC_TICK      = 3'd4;

  // Register selects.
  localparam logic [1:0] SEL_CTRL   = 2'd0;
  localparam logic [1:0] SEL_UNLOCK = 2'd1;
  localparam logic [1:0] SEL_PKEY   = 2'd2;
  localparam logic [1:0] SEL_STATUS = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_TICKS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_TICKS = 8'd1;

  typedef enum logic [2:0] {
    OP_REG_READ, OP_REG_WRITE, OP_MEM_READ, OP_MEM_WRITE, OP_TICK, OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MEM_RD, S_ERASE, S_WORD_WR, S_HP_RD, S_HP_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic              prog;
    logic              erase;
    logic              fprg;
    logic              eopie;
    logic              errie;
  } mode_t;

  typedef struct packed {
    logic              eop;
    logic              wrperr;
    logic              pgaerr;
  } flags_t;

  typedef struct packed {
    op_t               op;
    logic [1:0]        sel;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } item_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ===== hw/rtl/fpec_req_if.sv =====
// Request channel interface carrying one access word.
interface fpec_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [1:0]  reg_sel;
  logic [9:0]  word_addr;
  logic [31:0] wdata;

  modport source (output valid, func, reg_sel, word_addr, wdata, input ready);
  modport sink (input valid, func, reg_sel, word_addr, wdata, output ready);
endinterface

// ===== hw/rtl/fpec_rsp_if.sv =====
// Response channel interface carrying one result word.
interface fpec_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        busy_res;
  logic        done_irq;
  logic        error_irq;
  logic        access_refused;

  modport source (output valid, read_data, busy_res, done_irq, error_irq, access_refused,
                  input ready);
  modport sink (input valid, read_data, busy_res, done_irq, error_irq, access_refused,
                output ready);
endinterface

// ===== hw/rtl/fpec_cfg_if.sv =====
// Configuration write channel interface.
interface fpec_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/flash_program_erase_controller.sv =====
// Top level of the flash program/erase controller with key unlock.
// With the back end idle, register accesses, ticks, refused writes and buffered half-page
// words go from S_IDLE straight to S_DONE; memory reads pass S_MEM_RD, word programs
// S_WORD_WR, and a page erase (one array write per word) or a half-page flush (a read and a
// write per word) sweeps in S_ERASE or S_HP_RD/S_HP_WR. A word starts once the previous result
// is taken. Reset is synchronous; then the array is cleared to zero, one word per cycle.
module flash_program_erase_controller (
  input logic        clk,
  input logic        rst,
  fpec_req_if.sink   req,
  fpec_rsp_if.source rsp,
  fpec_cfg_if.sink   cfg
);
  import fpec_pkg::*;

  queue_head_t head;
  logic        pop;

  fpec_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .pop  (pop),
    .head (head)
  );

  fpec_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp),
    .cfg  (cfg)
  );
endmodule

// ===== hw/rtl/fpec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fpec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/fpec_front.sv =====
// Front end: accepts request words, decodes them and queues them for the back end.
module fpec_front (
  input  logic                  clk,
  input  logic                  rst,
  fpec_req_if.sink              req,
  input  logic                  pop,
  output fpec_pkg::queue_head_t head
);
  import fpec_pkg::*;

  item_t      slots [QUEUE_DEPTH];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  item_t      decoded;
  logic       push;

  // Classify the function code into an operation.
  always_comb begin
    case (req.func)
      FUNC_REG_READ:  decoded.op = OP_REG_READ;
      FUNC_REG_WRITE: decoded.op = OP_REG_WRITE;
      FUNC_MEM_READ:  decoded.op = OP_MEM_READ;
      FUNC_MEM_WRITE: decoded.op = OP_MEM_WRITE;
      FUNC_TICK:      decoded.op = OP_TICK;
      default:        decoded.op = OP_NOP;
    endcase
    decoded.sel  = req.reg_sel;
    decoded.addr = req.word_addr[ADDR_W-1:0];
    decoded.data = req.wdata;
  end

  assign req.ready  = (count != 2'(QUEUE_DEPTH));
  assign push       = req.valid && req.ready;
  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rptr];

  // Two-entry queue between the front and back ends.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= decoded;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== hw/rtl/fpec_back.sv =====
// Back end: executes queued words against the registers and the array, and returns results.
module fpec_back (
  input  logic                  clk,
  input  logic                  rst,
  input  fpec_pkg::queue_head_t head,
  output logic                  pop,
  fpec_rsp_if.source            rsp,
  fpec_cfg_if.sink              cfg
);
  import fpec_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [ADDR_W-1:0]   cnt;
  logic [TICK_W-1:0]   erase_ticks;
  logic [TICK_W-1:0]   program_ticks;
  logic [DATA_W-1:0]   hp_buf [HALF_PAGE_WORDS];
  logic [FILL_W-1:0]   buffer_fill;
  logic [ADDR_W-1:0]   hp_base;
  logic                unlock_stage;
  logic                pkey_stage;
  logic                control_lock;
  logic                program_lock;
  mode_t               mode;
  flags_t              flags;
  logic [TICK_W-1:0]   busy_count;
  logic [ADDR_W-1:0]   cur_addr;
  logic [DATA_W-1:0]   cur_data;
  logic [DATA_W-1:0]   rd;
  logic                refused;
  logic                res_valid;

  logic                start;
  item_t               it;
  logic                mem_blocked;
  logic                do_erase;
  logic                do_fprg;
  logic                do_word;
  logic                hp_last;
  logic [DATA_W-1:0]   ctrl_view;
  logic [DATA_W-1:0]   status_view;
  logic                refuse_now;
  logic [DATA_W-1:0]   start_rd;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  fpec_ram #(.WIDTH(DATA_W), .DEPTH(ARRAY_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An item starts only when the result register is free.
  assign it    = head.item;
  assign start = (state == S_IDLE) && head.valid && !res_valid;
  assign pop   = start;
  assign cfg.ready = 1'b1;

  assign mem_blocked = control_lock || program_lock || (busy_count != '0);
  assign do_erase    = mode.erase && mode.prog && !mode.fprg;
  assign do_fprg     = mode.fprg && mode.prog && !mode.erase;
  assign do_word     = !mode.erase && !mode.fprg;
  assign hp_last     = (buffer_fill == FILL_W'(HALF_PAGE_WORDS - 1));

  // Register views.
  always_comb begin
    ctrl_view      = '0;
    ctrl_view[0]   = control_lock;
    ctrl_view[1]   = program_lock;
    ctrl_view[3]   = mode.prog;
    ctrl_view[9]   = mode.erase;
    ctrl_view[10]  = mode.fprg;
    ctrl_view[16]  = mode.eopie;
    ctrl_view[17]  = mode.errie;
    status_view    = '0;
    status_view[0] = (busy_count != '0);
    status_view[1] = flags.eop;
    status_view[8] = flags.wrperr;
    status_view[9] = flags.pgaerr;
  end

  // Refusal and read data of the word at the head of the queue.
  always_comb begin
    refuse_now = 1'b0;
    start_rd   = '0;
    case (it.op)
      OP_REG_READ: begin
        if (it.sel == SEL_CTRL) start_rd = ctrl_view;
        else if (it.sel == SEL_STATUS) start_rd = status_view;
      end
      OP_REG_WRITE: begin
        case (it.sel)
          SEL_CTRL:   refuse_now = control_lock;
          SEL_UNLOCK: refuse_now = control_lock &&
                                   !((!unlock_stage && it.data == KEY_UNLOCK_A) ||
                                     (unlock_stage && it.data == KEY_UNLOCK_B));
          SEL_PKEY:   refuse_now = control_lock ||
                                   (program_lock &&
                                    !((!pkey_stage && it.data == KEY_PROG_A) ||
                                      (pkey_stage && it.data == KEY_PROG_B)));
          default:    refuse_now = 1'b0;
        endcase
      end
      OP_MEM_WRITE: refuse_now = mem_blocked || !(do_erase || do_fprg || do_word);
      default:      refuse_now = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (cnt == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_DONE;
          if (it.op == OP_MEM_READ) begin
            state_next = S_MEM_RD;
          end else if (it.op == OP_MEM_WRITE && !mem_blocked) begin
            if (do_erase) state_next = S_ERASE;
            else if (do_fprg && hp_last) state_next = S_HP_RD;
            else if (do_word && !do_fprg) state_next = S_WORD_WR;
          end
        end
      end
      S_MEM_RD:  state_next = S_DONE;
      S_ERASE: begin
        if (cnt[PAGE_W-1:0] == '1) state_next = S_DONE;
      end
      S_WORD_WR: state_next = S_DONE;
      S_HP_RD:   state_next = S_HP_WR;
      S_HP_WR: begin
        if (cnt[HP_W-1:0] == '1) state_next = S_DONE;
        else state_next = S_HP_RD;
      end
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Array port controls.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '0;
    ram_raddr = cur_addr;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_raddr = it.addr;
      end
      S_ERASE: begin
        ram_we    = 1'b1;
        ram_waddr = {cur_addr[ADDR_W-1:PAGE_W], cnt[PAGE_W-1:0]};
      end
      S_WORD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = ram_rdata | cur_data;
      end
      S_HP_RD: begin
        ram_raddr = {hp_base[ADDR_W-1:HP_W], cnt[HP_W-1:0]};
      end
      S_HP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {hp_base[ADDR_W-1:HP_W], cnt[HP_W-1:0]};
        ram_wdata = ram_rdata | hp_buf[cnt[HP_W-1:0]];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Gathered half-page words; no reset, read only after being filled.
  always_ff @(posedge clk) begin
    if (start && it.op == OP_MEM_WRITE && !mem_blocked && do_fprg) begin
      hp_buf[buffer_fill[HP_W-1:0]] <= it.data;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      rsp.read_data      <= rd;
      rsp.busy_res       <= (busy_count != '0);
      rsp.done_irq       <= flags.eop && mode.eopie;
      rsp.error_irq      <= (flags.wrperr || flags.pgaerr) && mode.errie;
      rsp.access_refused <= refused;
    end
  end
  assign rsp.valid = res_valid;

  // Control and status registers.
  always_ff @(posedge clk) begin
    if (start) begin
      cur_addr <= it.addr;
      cur_data <= it.data;
    end
    if (state == S_MEM_RD) begin
      rd <= ram_rdata;
    end
    if (rst) begin
      state         <= S_CLEAR;
      cnt           <= '0;
      erase_ticks   <= ERASE_TICKS_RESET;
      program_ticks <= PROGRAM_TICKS_RESET;
      buffer_fill   <= '0;
      hp_base       <= '0;
      unlock_stage  <= 1'b0;
      pkey_stage    <= 1'b0;
      control_lock  <= 1'b1;
      program_lock  <= 1'b1;
      mode          <= '0;
      flags         <= '0;
      busy_count    <= '0;
      refused       <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        if (cfg.index == CFG_ERASE_TICKS) erase_ticks <= cfg.data[TICK_W-1:0];
        if (cfg.index == CFG_PROGRAM_TICKS) program_ticks <= cfg.data[TICK_W-1:0];
      end

      if (rsp.valid && rsp.ready) res_valid <= 1'b0;
      if (state == S_DONE) res_valid <= 1'b1;

      // Sweep counter for the clearing pass, erase and half-page flush.
      if (state == S_CLEAR || state == S_ERASE || state == S_HP_WR) begin
        cnt <= cnt + 1'b1;
      end else if (state == S_IDLE) begin
        cnt <= '0;
      end

      if (start) begin
        refused <= refuse_now;
        rd      <= start_rd;
        case (it.op)
          OP_REG_WRITE: begin
            case (it.sel)
              SEL_CTRL: begin
                if (!control_lock) begin
                  mode.prog   <= it.data[3];
                  mode.erase  <= it.data[9];
                  mode.fprg   <= it.data[10];
                  mode.eopie  <= it.data[16];
                  mode.errie  <= it.data[17];
                  buffer_fill <= '0;
                  if (it.data[0]) begin
                    control_lock <= 1'b1;
                    program_lock <= 1'b1;
                    unlock_stage <= 1'b0;
                    pkey_stage   <= 1'b0;
                  end else if (it.data[1]) begin
                    program_lock <= 1'b1;
                    pkey_stage   <= 1'b0;
                  end
                end
              end
              SEL_UNLOCK: begin
                if (control_lock) begin
                  if (!unlock_stage && it.data == KEY_UNLOCK_A) begin
                    unlock_stage <= 1'b1;
                  end else if (unlock_stage && it.data == KEY_UNLOCK_B) begin
                    unlock_stage <= 1'b0;
                    control_lock <= 1'b0;
                  end else begin
                    unlock_stage <= 1'b0;
                  end
                end
              end
              SEL_PKEY: begin
                if (control_lock) begin
                  pkey_stage <= 1'b0;
                end else if (program_lock) begin
                  if (!pkey_stage && it.data == KEY_PROG_A) begin
                    pkey_stage <= 1'b1;
                  end else if (pkey_stage && it.data == KEY_PROG_B) begin
                    pkey_stage   <= 1'b0;
                    program_lock <= 1'b0;
                  end else begin
                    pkey_stage <= 1'b0;
                  end
                end
              end
              default: begin
                // Status flags clear when written with one.
                if (it.data[1]) flags.eop    <= 1'b0;
                if (it.data[8]) flags.wrperr <= 1'b0;
                if (it.data[9]) flags.pgaerr <= 1'b0;
              end
            endcase
          end
          OP_MEM_WRITE: begin
            if (mem_blocked) begin
              flags.wrperr <= 1'b1;
            end else if (do_erase) begin
              busy_count <= (erase_ticks == '0) ? TICK_W'(1) : erase_ticks;
            end else if (do_fprg) begin
              if (buffer_fill == '0) begin
                hp_base <= {it.addr[ADDR_W-1:HP_W], HP_W'(0)};
              end
              if (hp_last) begin
                buffer_fill <= '0;
                busy_count  <= (program_ticks == '0) ? TICK_W'(1) : program_ticks;
              end else begin
                buffer_fill <= buffer_fill + 1'b1;
              end
            end else if (do_word) begin
              busy_count <= (program_ticks == '0) ? TICK_W'(1) : program_ticks;
            end else begin
              flags.pgaerr <= 1'b1;
            end
          end
          OP_TICK: begin
            if (busy_count != '0) begin
              busy_count <= busy_count - 1'b1;
              if (busy_count == TICK_W'(1)) flags.eop <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the flash program/erase controller.
`timescale 1ns / 1ps

module testbench;
  import fpec_pkg::*;

  // Bit positions of the control and status register views.
  localparam int CTRL_LOCK  = 0;
  localparam int CTRL_PLOCK = 1;
  localparam int CTRL_PROG  = 3;
  localparam int CTRL_ERASE = 9;
  localparam int CTRL_FPRG  = 10;
  localparam int CTRL_EOPIE = 16;
  localparam int CTRL_ERRIE = 17;
  localparam int STAT_BUSY   = 0;
  localparam int STAT_EOP    = 1;
  localparam int STAT_WRPERR = 8;
  localparam int STAT_PGAERR = 9;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_TICK_RUN  = 64;

  typedef struct {
    logic [31:0] read_data;
    logic        busy_res;
    logic        done_irq;
    logic        error_irq;
    logic        access_refused;
  } flash_result_t;

  logic clk;
  logic rst;

  fpec_req_if req_bus ();
  fpec_rsp_if rsp_bus ();
  fpec_cfg_if cfg_bus ();

  flash_program_erase_controller u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus.sink),
    .rsp (rsp_bus.source),
    .cfg (cfg_bus.sink)
  );

  // Shadow copy of the controller state.
  logic [31:0]       flash_mem [ARRAY_WORDS];
  logic [31:0]       gather_buf [HALF_PAGE_WORDS];
  logic [FILL_W-1:0] gather_fill;
  logic [ADDR_W-1:0] gather_base;
  logic              unlock_step;
  logic              pkey_step;
  logic              ctrl_locked;
  logic              prog_locked;
  mode_t             mode;
  flags_t            flags;
  logic [TICK_W-1:0] busy_left;
  logic [TICK_W-1:0] erase_len;
  logic [TICK_W-1:0] program_len;

  flash_result_t expected_results[$];
  int  error_count;
  int  words_sent;
  int  words_checked;
  int  erases_done;
  int  word_programs_done;
  int  half_pages_done;
  int  burst_left;
  bit  sender_gaps;

  // Clock generation.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Start of the busy period.
  function automatic logic [TICK_W-1:0] busy_start(input logic [TICK_W-1:0] ticks);
    return (ticks == '0) ? TICK_W'(1) : ticks;
  endfunction

  // Register write; returns 1 when the write is refused.
  function automatic logic apply_reg_write(input logic [1:0] sel, input logic [31:0] d);
    case (sel)
      SEL_CTRL: begin
        if (ctrl_locked) return 1'b1;
        mode.prog  = d[CTRL_PROG];
        mode.erase = d[CTRL_ERASE];
        mode.fprg  = d[CTRL_FPRG];
        mode.eopie = d[CTRL_EOPIE];
        mode.errie = d[CTRL_ERRIE];
        gather_fill = '0;
        if (d[CTRL_PLOCK]) begin
          prog_locked = 1'b1;
          pkey_step = 1'b0;
        end
        if (d[CTRL_LOCK]) begin
          ctrl_locked = 1'b1;
          prog_locked = 1'b1;
          unlock_step = 1'b0;
          pkey_step = 1'b0;
        end
        return 1'b0;
      end
      SEL_UNLOCK: begin
        if (!ctrl_locked) return 1'b0;
        if (!unlock_step && d == KEY_UNLOCK_A) begin
          unlock_step = 1'b1;
          return 1'b0;
        end
        if (unlock_step && d == KEY_UNLOCK_B) begin
          unlock_step = 1'b0;
          ctrl_locked = 1'b0;
          return 1'b0;
        end
        unlock_step = 1'b0;
        return 1'b1;
      end
      SEL_PKEY: begin
        if (ctrl_locked) begin
          pkey_step = 1'b0;
          return 1'b1;
        end
        if (!prog_locked) return 1'b0;
        if (!pkey_step && d == KEY_PROG_A) begin
          pkey_step = 1'b1;
          return 1'b0;
        end
        if (pkey_step && d == KEY_PROG_B) begin
          pkey_step = 1'b0;
          prog_locked = 1'b0;
          return 1'b0;
        end
        pkey_step = 1'b0;
        return 1'b1;
      end
      default: begin
        // Status flags clear on writing one.
        if (d[STAT_EOP]) flags.eop = 1'b0;
        if (d[STAT_WRPERR]) flags.wrperr = 1'b0;
        if (d[STAT_PGAERR]) flags.pgaerr = 1'b0;
        return 1'b0;
      end
    endcase
  endfunction

  // Array write in the current mode; returns 1 when the write is refused.
  function automatic logic apply_mem_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
    logic [ADDR_W-1:0] base;
    if (ctrl_locked || prog_locked || busy_left != '0) begin
      flags.wrperr = 1'b1;
      return 1'b1;
    end
    if (mode.erase && mode.prog && !mode.fprg) begin
      base = {a[ADDR_W-1:PAGE_W], PAGE_W'(0)};
      for (int i = 0; i < PAGE_WORDS; i++) flash_mem[base + i] = '0;
      busy_left = busy_start(erase_len);
      erases_done++;
      return 1'b0;
    end
    if (mode.fprg && mode.prog && !mode.erase) begin
      if (gather_fill == '0) gather_base = {a[ADDR_W-1:HP_W], HP_W'(0)};
      gather_buf[gather_fill[HP_W-1:0]] = d;
      gather_fill++;
      if (gather_fill == HALF_PAGE_WORDS) begin
        for (int i = 0; i < HALF_PAGE_WORDS; i++)
          flash_mem[gather_base + i] |= gather_buf[i];
        gather_fill = '0;
        busy_left = busy_start(program_len);
        half_pages_done++;
      end
      return 1'b0;
    end
    if (!mode.erase && !mode.fprg) begin
      flash_mem[a] |= d;
      busy_left = busy_start(program_len);
      word_programs_done++;
      return 1'b0;
    end
    flags.pgaerr = 1'b1;
    return 1'b1;
  endfunction

  // Advances the shadow state by one accepted word and returns the result it causes.
  function automatic flash_result_t predict_access(input logic [2:0] f, input logic [1:0] sel,
                                                   input logic [9:0] a, input logic [31:0] d);
    flash_result_t r;
    r.read_data = '0;
    r.access_refused = 1'b0;
    case (f)
      FUNC_REG_READ: begin
        if (sel == SEL_CTRL) begin
          r.read_data[CTRL_LOCK]  = ctrl_locked;
          r.read_data[CTRL_PLOCK] = prog_locked;
          r.read_data[CTRL_PROG]  = mode.prog;
          r.read_data[CTRL_ERASE] = mode.erase;
          r.read_data[CTRL_FPRG]  = mode.fprg;
          r.read_data[CTRL_EOPIE] = mode.eopie;
          r.read_data[CTRL_ERRIE] = mode.errie;
        end else if (sel == SEL_STATUS) begin
          r.read_data[STAT_BUSY]   = (busy_left != '0);
          r.read_data[STAT_EOP]    = flags.eop;
          r.read_data[STAT_WRPERR] = flags.wrperr;
          r.read_data[STAT_PGAERR] = flags.pgaerr;
        end
      end
      FUNC_REG_WRITE: r.access_refused = apply_reg_write(sel, d);
      FUNC_MEM_READ:  r.read_data = flash_mem[a];
      FUNC_MEM_WRITE: r.access_refused = apply_mem_write(a, d);
      FUNC_TICK: begin
        if (busy_left != '0) begin
          busy_left--;
          if (busy_left == '0) flags.eop = 1'b1;
        end
      end
      default: ;
    endcase
    r.busy_res  = (busy_left != '0);
    r.done_irq  = flags.eop && mode.eopie;
    r.error_irq = (flags.wrperr || flags.pgaerr) && mode.errie;
    return r;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Sends one request word in bursts separated by random gaps when sender gaps are enabled.
  task automatic send_word(input logic [2:0] f, input logic [1:0] sel,
                           input logic [9:0] a, input logic [31:0] d);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_gaps) gap = $urandom_range(1, 6);
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk);
      req_bus.valid <= 1'b0;
    end
    @(negedge clk);
    req_bus.valid     <= 1'b1;
    req_bus.func      <= f;
    req_bus.reg_sel   <= sel;
    req_bus.word_addr <= a;
    req_bus.wdata     <= d;
    do @(posedge clk); while (!req_bus.ready);
    expected_results.push_back(predict_access(f, sel, a, d));
    words_sent++;
  endtask

  // Writes one configuration register with the request valid dropped.
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    @(negedge clk);
    req_bus.valid <= 1'b0;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == CFG_ERASE_TICKS) erase_len = d[TICK_W-1:0];
    else if (idx == CFG_PROGRAM_TICKS) program_len = d[TICK_W-1:0];
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Holds the sender until every expected word has come back, then lets the block settle.
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // Ticks a short busy period away; a long one is left running.
  task automatic send_ticks_until_free();
    while (busy_left != '0 && busy_left <= TICK_W'(MAX_TICK_RUN))
      send_word(FUNC_TICK, SEL_CTRL, 10'($urandom), $urandom);
  endtask

  // Opens both locks if needed and loads the given control value.
  task automatic open_and_set_mode(input logic [31:0] ctrl);
    if (ctrl_locked) begin
      send_word(FUNC_REG_WRITE, SEL_UNLOCK, '0, KEY_UNLOCK_A);
      send_word(FUNC_REG_WRITE, SEL_UNLOCK, '0, KEY_UNLOCK_B);
    end
    if (prog_locked) begin
      send_word(FUNC_REG_WRITE, SEL_PKEY, '0, KEY_PROG_A);
      send_word(FUNC_REG_WRITE, SEL_PKEY, '0, KEY_PROG_B);
    end
    send_word(FUNC_REG_WRITE, SEL_CTRL, '0, ctrl);
  endtask

  function automatic logic [31:0] irq_bits();
    logic [31:0] v;
    v = '0;
    v[CTRL_EOPIE] = $urandom_range(0, 3) != 0;
    v[CTRL_ERRIE] = $urandom_range(0, 3) != 0;
    return v;
  endfunction

  function automatic logic [31:0] any_key();
    case ($urandom_range(0, 4))
      0: return KEY_UNLOCK_A;
      1: return KEY_UNLOCK_B;
      2: return KEY_PROG_A;
      3: return KEY_PROG_B;
      default: return $urandom;
    endcase
  endfunction

  // Lock behavior, refused accesses and wrong keys.
  task automatic test_locking();
    send_word(FUNC_REG_READ, SEL_CTRL, '0, '0);
    send_word(FUNC_REG_WRITE, SEL_CTRL, '0, 32'h0003_0608);
    send_word(FUNC_MEM_WRITE, SEL_CTRL, 10'h3FF, '1);
    send_word(FUNC_REG_WRITE, SEL_PKEY, '0, KEY_PROG_A);
    send_word(FUNC_REG_WRITE, SEL_UNLOCK, '0, KEY_UNLOCK_A);
    send_word(FUNC_REG_WRITE, SEL_UNLOCK, '0, 32'hFFFF_FFFF);
    send_word(FUNC_REG_WRITE, SEL_UNLOCK, '0, KEY_UNLOCK_A);
    send_word(FUNC_REG_WRITE, SEL_UNLOCK, '0, KEY_UNLOCK_B);
    send_word(FUNC_REG_WRITE, SEL_UNLOCK, '0, 32'h0000_0000);
    send_word(FUNC_REG_WRITE, SEL_PKEY, '0, KEY_PROG_B);
    send_word(FUNC_REG_WRITE, SEL_PKEY, '0, KEY_PROG_A);
    send_word(FUNC_REG_WRITE, SEL_PKEY, '0, KEY_PROG_B);
    send_word(FUNC_REG_READ, SEL_UNLOCK, '0, '0);
    send_word(FUNC_REG_READ, SEL_STATUS, '0, '0);
  endtask

  // Word program at the array edges, invalid mode, erase and flag clearing.
  task automatic test_operations();
    send_word(FUNC_REG_WRITE, SEL_CTRL, '0, 32'h0003_0008);
    send_word(FUNC_MEM_WRITE, SEL_CTRL, 10'h3FF, 32'hFFFF_FFFF);
    send_word(FUNC_MEM_WRITE, SEL_CTRL, 10'h000, 32'h0000_0001);
    send_ticks_until_free();
    send_word(FUNC_MEM_WRITE, SEL_CTRL, 10'h000, 32'h8000_0000);
    send_ticks_until_free();
    send_word(FUNC_MEM_READ, SEL_CTRL, 10'h3FF, '0);
    send_word(FUNC_MEM_READ, SEL_CTRL, 10'h000, '0);
    send_word(FUNC_REG_WRITE, SEL_CTRL, '0, 32'h0003_0600);
    send_word(FUNC_MEM_WRITE, SEL_CTRL, 10'h010, 32'h1234_5678);
    send_word(FUNC_REG_WRITE, SEL_CTRL, '0, 32'h0003_0208);
    send_word(FUNC_MEM_WRITE, SEL_CTRL, 10'h3E5, '0);
    send_ticks_until_free();
    send_word(FUNC_MEM_READ, SEL_CTRL, 10'h3FF, '0);
    send_word(FUNC_REG_WRITE, SEL_STATUS, '0, 32'hFFFF_FFFF);
    send_word(FUNC_REG_WRITE, SEL_CTRL, '0, 32'h0000_0001);
  endtask

  // Random traffic: mostly well-formed operations with random content, some noise.
  task automatic test_random_traffic(input int count);
    int stop_at;
    int n;
    logic [31:0] ctrl;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1: send_word(3'($urandom_range(0, 4)), 2'($urandom), 10'($urandom), any_key());
        2: begin
          // Word program followed by a read back.
          open_and_set_mode(irq_bits() | (32'd1 << CTRL_PROG));
          n = $urandom;
          send_word(FUNC_MEM_WRITE, 2'($urandom), 10'(n), $urandom);
          if ($urandom_range(0, 3) == 0)
            send_word(FUNC_MEM_WRITE, 2'($urandom), 10'($urandom), $urandom);
          send_ticks_until_free();
          send_word(FUNC_MEM_READ, 2'($urandom), 10'(n), $urandom);
        end
        3: begin
          open_and_set_mode(irq_bits() | (32'd1 << CTRL_PROG) | (32'd1 << CTRL_ERASE));
          send_word(FUNC_MEM_WRITE, 2'($urandom), 10'($urandom), $urandom);
          send_ticks_until_free();
        end
        4, 5: begin
          // Half page gathering, now and then abandoned by a control write.
          open_and_set_mode(irq_bits() | (32'd1 << CTRL_PROG) | (32'd1 << CTRL_FPRG));
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : HALF_PAGE_WORDS;
          repeat (n) send_word(FUNC_MEM_WRITE, 2'($urandom), 10'($urandom), $urandom);
          if (n < HALF_PAGE_WORDS) send_word(FUNC_REG_WRITE, SEL_CTRL, '0, irq_bits());
          send_ticks_until_free();
        end
        6: begin
          ctrl = $urandom;
          if ($urandom_range(0, 1) == 0) ctrl[1:0] = 2'b00;
          open_and_set_mode(ctrl);
          send_word(FUNC_MEM_WRITE, 2'($urandom), 10'($urandom), $urandom);
        end
        7: send_word(FUNC_MEM_READ, 2'($urandom), 10'($urandom), $urandom);
        8: send_word(FUNC_REG_READ, 2'($urandom), 10'($urandom), $urandom);
        default: send_word(FUNC_REG_WRITE, SEL_STATUS, 10'($urandom), $urandom);
      endcase
    end
  endtask

  // Receiver stalls: phases of full readiness and of random or periodic stalls.
  int stall_phase_left;
  int stall_kind;
  int stall_count;
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_phase_left = $urandom_range(40, 300);
      stall_kind = $urandom_range(0, 2);
    end
    stall_phase_left--;
    stall_count++;
    case (stall_kind)
      0: rsp_bus.ready <= 1'b1;
      1: rsp_bus.ready <= $urandom_range(0, 2) != 0;
      default: rsp_bus.ready <= (stall_count % 5) < 2;
    endcase
  end

  // Result checker.
  always @(posedge clk) begin
    flash_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_results.size() == 0) begin
        $display("[%0t] result word with nothing expected", $time);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        words_checked++;
        if (rsp_bus.read_data !== want.read_data)
          report("read_data", rsp_bus.read_data, want.read_data);
        if (rsp_bus.busy_res !== want.busy_res)
          report("busy_res", rsp_bus.busy_res, want.busy_res);
        if (rsp_bus.done_irq !== want.done_irq)
          report("done_irq", rsp_bus.done_irq, want.done_irq);
        if (rsp_bus.error_irq !== want.error_irq)
          report("error_irq", rsp_bus.error_irq, want.error_irq);
        if (rsp_bus.access_refused !== want.access_refused)
          report("access_refused", rsp_bus.access_refused, want.access_refused);
      end
    end
  end

  // Overall time limit.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.func = '0;
    req_bus.reg_sel = '0;
    req_bus.word_addr = '0;
    req_bus.wdata = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    for (int i = 0; i < ARRAY_WORDS; i++) flash_mem[i] = '0;
    for (int i = 0; i < HALF_PAGE_WORDS; i++) gather_buf[i] = '0;
    gather_fill = '0;
    gather_base = '0;
    unlock_step = 1'b0;
    pkey_step = 1'b0;
    ctrl_locked = 1'b1;
    prog_locked = 1'b1;
    mode = '0;
    flags = '0;
    busy_left = '0;
    erase_len = ERASE_TICKS_RESET;
    program_len = PROGRAM_TICKS_RESET;
    error_count = 0;
    words_sent = 0;
    words_checked = 0;
    erases_done = 0;
    word_programs_done = 0;
    half_pages_done = 0;
    burst_left = 0;
    stall_phase_left = 0;
    stall_kind = 0;
    stall_count = 0;
    sender_gaps = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with the minimum tick counts, zero acting as one.
    write_setting(CFG_ERASE_TICKS, 32'd0);
    write_setting(CFG_PROGRAM_TICKS, 32'd1);
    test_locking();
    test_operations();
    wait_idle();

    sender_gaps = 1'b1;
    write_setting(CFG_ERASE_TICKS, 32'd3);
    write_setting(CFG_PROGRAM_TICKS, 32'd2);
    test_random_traffic(350);
    wait_idle();

    sender_gaps = 1'b0;
    write_setting(CFG_ERASE_TICKS, 32'd7);
    write_setting(CFG_PROGRAM_TICKS, 32'd1);
    test_random_traffic(350);
    wait_idle();

    // Largest tick counts last: once started, an operation stays busy for good.
    sender_gaps = 1'b1;
    write_setting(CFG_ERASE_TICKS, 32'hFFFF);
    write_setting(CFG_PROGRAM_TICKS, 32'hFFFF);
    test_random_traffic(50);
    wait_idle();

    $display("Sent %0d words, checked %0d results.", words_sent, words_checked);
    $display("Covered %0d page erases, %0d word programs and %0d half-page programs.",
             erases_done, word_programs_done, half_pages_done);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
